>>> hdl/rti_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants and types for the ray/triangle intersection test.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int CFG_WIDTH       = 60;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_VERTEX_A,
    REG_VERTEX_B,
    REG_VERTEX_C
  } cfg_reg_t;

endpackage
`default_nettype wire

>>> hdl/rti_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rti_cfg
// Vertex registers, triangle edges and the coincident-vertex check.
// ----------------------------------------------------------------------------
module rti_cfg import rti_pkg::*; #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [CFG_WIDTH-1:0]          cfg_data,
  output logic signed [COORD_WIDTH-1:0]      vtx_a [3],
  output logic signed [COORD_WIDTH:0]        edge1 [3],
  output logic signed [COORD_WIDTH:0]        edge2 [3],
  output logic                               same
);

  localparam int PW = 3 * COORD_WIDTH;
  localparam int SW = (PW < CFG_WIDTH) ? PW : CFG_WIDTH;

  logic [SW-1:0]                 vtx_reg [3];
  logic [PW-1:0]                 vtx_ext [3];
  logic signed [COORD_WIDTH-1:0] crd [3][3];
  logic                          ab, bc, ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_reg[0] <= '0;
      vtx_reg[1] <= '0;
      vtx_reg[2] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VERTEX_A: vtx_reg[0] <= cfg_data[SW-1:0];
        REG_VERTEX_B: vtx_reg[1] <= cfg_data[SW-1:0];
        REG_VERTEX_C: vtx_reg[2] <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // bits above the register width read as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vtx_ext[i] = PW'(vtx_reg[i]);
      for (int k = 0; k < 3; k++) begin
        crd[i][k] = vtx_ext[i][k*COORD_WIDTH +: COORD_WIDTH];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vtx_a[k] = crd[0][k];
      edge1[k] = (COORD_WIDTH+1)'(crd[1][k]) - (COORD_WIDTH+1)'(crd[0][k]);
      edge2[k] = (COORD_WIDTH+1)'(crd[2][k]) - (COORD_WIDTH+1)'(crd[0][k]);
    end
  end

  assign ab   = (crd[0][0] == crd[1][0]) && (crd[0][1] == crd[1][1]) &&
                (crd[0][2] == crd[1][2]);
  assign bc   = (crd[1][0] == crd[2][0]) && (crd[1][1] == crd[2][1]) &&
                (crd[1][2] == crd[2][2]);
  assign ac   = (crd[0][0] == crd[2][0]) && (crd[0][1] == crd[2][1]) &&
                (crd[0][2] == crd[2][2]);
  assign same = ab || bc || ac;

endmodule
`default_nettype wire

>>> hdl/rti_cross.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rti_cross
// Three stages: origin offset, cross-product multiplies, cross differences.
// Produces S = O - A, S1 = D x E2 and S2 = S x E1.
// ----------------------------------------------------------------------------
module rti_cross #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            up_valid,
  output logic                                 up_stall,
  input  wire logic signed [COORD_WIDTH-1:0]   origin [3],
  input  wire logic signed [COORD_WIDTH-1:0]   direction [3],
  input  wire logic signed [COORD_WIDTH-1:0]   vtx_a [3],
  input  wire logic signed [COORD_WIDTH:0]     edge1 [3],
  input  wire logic signed [COORD_WIDTH:0]     edge2 [3],
  output logic                                 dn_valid,
  input  wire logic                            dn_stall,
  output logic signed [COORD_WIDTH:0]          s_out [3],
  output logic signed [COORD_WIDTH-1:0]        d_out [3],
  output logic signed [2*COORD_WIDTH+1:0]      s1 [3],
  output logic signed [2*COORD_WIDTH+2:0]      s2 [3]
);

  localparam int W = COORD_WIDTH;

  logic               v0, v1, v2;
  logic               rdy0, rdy1, rdy2;

  logic signed [W:0]     s0 [3];
  logic signed [W-1:0]   d0 [3];
  logic signed [2*W:0]   pd [3][2];
  logic signed [2*W+1:0] ps [3][2];
  logic signed [W:0]     s1r [3];
  logic signed [W-1:0]   d1 [3];

  assign rdy2     = !v2 || !dn_stall;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign up_stall = !rdy0;
  assign dn_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= up_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      for (int k = 0; k < 3; k++) begin
        s0[k] <= (W+1)'(origin[k]) - (W+1)'(vtx_a[k]);
        d0[k] <= direction[k];
      end
    end
    if (rdy1) begin
      // D x E2 and S x E1 term by term
      pd[0][0] <= d0[1] * edge2[2];
      pd[0][1] <= d0[2] * edge2[1];
      pd[1][0] <= d0[2] * edge2[0];
      pd[1][1] <= d0[0] * edge2[2];
      pd[2][0] <= d0[0] * edge2[1];
      pd[2][1] <= d0[1] * edge2[0];
      ps[0][0] <= s0[1] * edge1[2];
      ps[0][1] <= s0[2] * edge1[1];
      ps[1][0] <= s0[2] * edge1[0];
      ps[1][1] <= s0[0] * edge1[2];
      ps[2][0] <= s0[0] * edge1[1];
      ps[2][1] <= s0[1] * edge1[0];
      for (int k = 0; k < 3; k++) begin
        s1r[k] <= s0[k];
        d1[k]  <= d0[k];
      end
    end
    if (rdy2) begin
      for (int k = 0; k < 3; k++) begin
        s1[k]    <= (2*W+2)'(pd[k][0]) - (2*W+2)'(pd[k][1]);
        s2[k]    <= (2*W+3)'(ps[k][0]) - (2*W+3)'(ps[k][1]);
        s_out[k] <= s1r[k];
        d_out[k] <= d1[k];
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/rti_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rti_dot
// Two stages: nine products, then the three-term sums
// det = S1.E1, n1 = S1.S, n2 = S2.D.
// ----------------------------------------------------------------------------
module rti_dot #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            up_valid,
  output logic                                 up_stall,
  input  wire logic signed [COORD_WIDTH:0]     s_in [3],
  input  wire logic signed [COORD_WIDTH-1:0]   d_in [3],
  input  wire logic signed [2*COORD_WIDTH+1:0] s1 [3],
  input  wire logic signed [2*COORD_WIDTH+2:0] s2 [3],
  input  wire logic signed [COORD_WIDTH:0]     edge1 [3],
  output logic                                 dn_valid,
  input  wire logic                            dn_stall,
  output logic signed [3*COORD_WIDTH+4:0]      det,
  output logic signed [3*COORD_WIDTH+4:0]      n1,
  output logic signed [3*COORD_WIDTH+4:0]      n2
);

  localparam int W  = COORD_WIDTH;
  localparam int RW = 3*W + 5;

  logic v0, v1;
  logic rdy0, rdy1;

  logic signed [3*W+2:0] pe [3];
  logic signed [3*W+2:0] pn [3];
  logic signed [3*W+2:0] pm [3];

  assign rdy1     = !v1 || !dn_stall;
  assign rdy0     = !v0 || rdy1;
  assign up_stall = !rdy0;
  assign dn_valid = v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (rdy0) v0 <= up_valid;
      if (rdy1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      for (int k = 0; k < 3; k++) begin
        pe[k] <= s1[k] * edge1[k];
        pn[k] <= s1[k] * s_in[k];
        pm[k] <= s2[k] * d_in[k];
      end
    end
    if (rdy1) begin
      det <= RW'(pe[0]) + RW'(pe[1]) + RW'(pe[2]);
      n1  <= RW'(pn[0]) + RW'(pn[1]) + RW'(pn[2]);
      n2  <= RW'(pm[0]) + RW'(pm[1]) + RW'(pm[2]);
    end
  end

endmodule
`default_nettype wire

>>> hdl/rti_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rti_decide
// Sign normalization against det, then the inside test and output register.
// ----------------------------------------------------------------------------
module rti_decide #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            up_valid,
  output logic                                 up_stall,
  input  wire logic signed [3*COORD_WIDTH+4:0] det,
  input  wire logic signed [3*COORD_WIDTH+4:0] n1,
  input  wire logic signed [3*COORD_WIDTH+4:0] n2,
  input  wire logic                            same,
  output logic                                 dn_valid,
  input  wire logic                            dn_stall,
  output logic                                 hit,
  output logic                                 degenerate
);

  localparam int DW = 3*COORD_WIDTH + 8;

  logic v0, v1;
  logic rdy0, rdy1;

  logic                 deg0;
  logic signed [DW-1:0] dabs, m1, m2;
  logic signed [DW-1:0] slack;
  logic                 det_neg;

  assign rdy1     = !v1 || !dn_stall;
  assign rdy0     = !v0 || rdy1;
  assign up_stall = !rdy0;
  assign dn_valid = v1;
  assign det_neg  = det[3*COORD_WIDTH+4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (rdy0) v0 <= up_valid;
      if (rdy1) v1 <= v0;
    end
  end

  // |det| - (n1 + n2) after folding the sign of det into the numerators
  assign slack = dabs - m1 - m2;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      deg0 <= same || (det == '0);
      dabs <= det_neg ? -DW'(det) : DW'(det);
      m1   <= det_neg ? -DW'(n1)  : DW'(n1);
      m2   <= det_neg ? -DW'(n2)  : DW'(n2);
    end
    if (rdy1) begin
      degenerate <= deg0;
      hit        <= !deg0 && !m1[DW-1] && !m2[DW-1] && !slack[DW-1];
    end
  end

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (v0 && rdy1) |=> dn_valid)
    else $error("decide: stage result did not reach the output register");

endmodule
`default_nettype wire

>>> hdl/ray_triangle_intersection_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_intersection_test
// Line/triangle hit test over a triangle held in three vertex registers.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, origin_*, direction_*| into block
//   out     | out_valid, out_stall, hit, degenerate    | out of block
//   cfg     | cfg_write, cfg_index, cfg_data           | into block
//
// One line per clock while the output is not stalled; one register
// per step, in order: origin offset, cross multiplies, cross differences, dot multiplies,
// dot sums, sign fold against det, final decision.
// Reset clears the pipeline valid bits and the vertex registers.
// A stall ripples back through the stage ready chain; empty stages still
// take data, so bubbles close up and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ray_triangle_intersection_test import rti_pkg::*; #(
  parameter int COORD_WIDTH = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [CFG_WIDTH-1:0]          cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] origin_x,
  input  wire logic signed [COORD_WIDTH-1:0] origin_y,
  input  wire logic signed [COORD_WIDTH-1:0] origin_z,
  input  wire logic signed [COORD_WIDTH-1:0] direction_x,
  input  wire logic signed [COORD_WIDTH-1:0] direction_y,
  input  wire logic signed [COORD_WIDTH-1:0] direction_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic                               degenerate
);

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0]   origin [3];
  logic signed [W-1:0]   direction [3];
  logic signed [W-1:0]   vtx_a [3];
  logic signed [W:0]     edge1 [3];
  logic signed [W:0]     edge2 [3];
  logic                  same;

  logic                  x_valid, x_stall;
  logic signed [W:0]     x_s [3];
  logic signed [W-1:0]   x_d [3];
  logic signed [2*W+1:0] x_s1 [3];
  logic signed [2*W+2:0] x_s2 [3];

  logic                  p_valid, p_stall;
  logic signed [3*W+4:0] det, n1, n2;

  assign origin[0]    = origin_x;
  assign origin[1]    = origin_y;
  assign origin[2]    = origin_z;
  assign direction[0] = direction_x;
  assign direction[1] = direction_y;
  assign direction[2] = direction_z;

  rti_cfg #(.COORD_WIDTH(W)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx_a     (vtx_a),
    .edge1     (edge1),
    .edge2     (edge2),
    .same      (same)
  );

  rti_cross #(.COORD_WIDTH(W)) u_cross (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (in_valid),
    .up_stall  (in_stall),
    .origin    (origin),
    .direction (direction),
    .vtx_a     (vtx_a),
    .edge1     (edge1),
    .edge2     (edge2),
    .dn_valid  (x_valid),
    .dn_stall  (x_stall),
    .s_out     (x_s),
    .d_out     (x_d),
    .s1        (x_s1),
    .s2        (x_s2)
  );

  rti_dot #(.COORD_WIDTH(W)) u_dot (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (x_valid),
    .up_stall  (x_stall),
    .s_in      (x_s),
    .d_in      (x_d),
    .s1        (x_s1),
    .s2        (x_s2),
    .edge1     (edge1),
    .dn_valid  (p_valid),
    .dn_stall  (p_stall),
    .det       (det),
    .n1        (n1),
    .n2        (n2)
  );

  rti_decide #(.COORD_WIDTH(W)) u_decide (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (p_valid),
    .up_stall   (p_stall),
    .det        (det),
    .n1         (n1),
    .n2         (n2),
    .same       (same),
    .dn_valid   (out_valid),
    .dn_stall   (out_stall),
    .hit        (hit),
    .degenerate (degenerate)
  );

  // input back-pressure only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_deg_no_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> !hit)
    else $error("hit reported on a degenerate case");

  // a fresh output beat crossed the two decide registers from the dot stage
  a_out_needs_in: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(p_valid, 2))
    else $error("output beat appeared without a beat from the dot stage");

endmodule
`default_nettype wire

>>> dv/tb_ray_triangle_intersection_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersection_test
// Self-checking bench for the line/triangle hit test. Most phases load a
// triangle through the register port while the block is idle. It then
// streams lines at it: directed corner and edge cases first, then random
// lines. Most random lines are aimed at or just past the triangle; the rest
// are full-range noise. Every accepted line is scored by an exact wide-integer
// predictor, and results are checked in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersection_test;
  import rti_pkg::*;

  localparam int CW    = 20;
  localparam int CMAX  = 2 ** (CW - 1) - 1;
  localparam int CMIN  = -(2 ** (CW - 1));
  localparam int LIMIT = 400000;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;  // unmapped index

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [CW-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic hit;
    logic degenerate;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [CW-1:0]       origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [CW-1:0]       direction_x = '0, direction_y = '0, direction_z = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       hit;
  logic                       degenerate;

  ray_t           pending_rays[$];
  verdict_t       expected_verdicts[$];
  logic [59:0]    vertex_regs[3] = '{default: '0};
  ray_t           cur_ray;
  bit             steady = 1'b0;
  int             in_gap = 0;
  int             stall_left = 0;
  int             cycles = 0;
  int             errors = 0;
  int             n_hits = 0, n_miss = 0, n_degen = 0, n_sent = 0;
  int             triangles = 0, cfg_writes = 0;

  ray_triangle_intersection_test #(.COORD_WIDTH(CW)) dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint vcoord(int v, int k);
    logic signed [CW-1:0] f;
    f = vertex_regs[v][k*CW +: CW];
    return longint'(f);
  endfunction

  function automatic wide_t dot3(input longint p[3], input longint q[3]);
    return wide_t'(p[0]) * wide_t'(q[0]) + wide_t'(p[1]) * wide_t'(q[1]) +
           wide_t'(p[2]) * wide_t'(q[2]);
  endfunction

  function automatic verdict_t classify_ray(ray_t r);
    longint   o[3], d[3], e1[3], e2[3], s[3], s1[3], s2[3];
    wide_t    det, n1, n2;
    verdict_t v;
    o[0] = longint'(r.ox); o[1] = longint'(r.oy); o[2] = longint'(r.oz);
    d[0] = longint'(r.dx); d[1] = longint'(r.dy); d[2] = longint'(r.dz);
    for (int k = 0; k < 3; k++) begin
      e1[k] = vcoord(1, k) - vcoord(0, k);
      e2[k] = vcoord(2, k) - vcoord(0, k);
      s[k]  = o[k] - vcoord(0, k);
    end
    s1[0] = d[1] * e2[2] - d[2] * e2[1];
    s1[1] = d[2] * e2[0] - d[0] * e2[2];
    s1[2] = d[0] * e2[1] - d[1] * e2[0];
    s2[0] = s[1] * e1[2] - s[2] * e1[1];
    s2[1] = s[2] * e1[0] - s[0] * e1[2];
    s2[2] = s[0] * e1[1] - s[1] * e1[0];
    det = dot3(s1, e1);
    n1  = dot3(s1, s);
    n2  = dot3(s2, d);
    v = '0;
    if (vertex_regs[0] == vertex_regs[1] || vertex_regs[1] == vertex_regs[2] ||
        vertex_regs[0] == vertex_regs[2] || det == 0) begin
      v.degenerate = 1'b1;
    end else begin
      // fold the determinant sign into the numerators
      if (det < 0) begin
        det = -det;
        n1  = -n1;
        n2  = -n2;
      end
      v.hit = (n1 >= 0) && (n2 >= 0) && (n1 + n2 <= det);
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Driver and monitor
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  always @(posedge clk) begin : line_driver
    ray_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_verdicts.push_back(classify_ray(cur_ray));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_rays.size() > 0) begin
          nxt = pending_rays.pop_front();
          cur_ray = nxt;
          origin_x    <= nxt.ox;
          origin_y    <= nxt.oy;
          origin_z    <= nxt.oz;
          direction_x <= nxt.dx;
          direction_y <= nxt.dy;
          direction_z <= nxt.dz;
          in_valid    <= 1'b1;
          in_gap = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : verdict_monitor
    verdict_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no line outstanding");
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, hit);
            errors++;
          end
          if (degenerate !== want.degenerate) begin
            $error("degenerate: expected %0b, got %0b", want.degenerate, degenerate);
            errors++;
          end
          if (want.degenerate) n_degen++;
          else if (want.hit) n_hits++;
          else n_miss++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = ($urandom_range(3) == 0) ? idle_len() : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [59:0] vpack(int x, int y, int z);
    return {CW'(z), CW'(y), CW'(x)};
  endfunction

  function automatic logic signed [CW-1:0] rnd_coord(int span);
    if (span < 0) begin
      case ($urandom_range(3))
        0:       return CW'(CMIN);
        1:       return CW'(CMAX);
        2:       return '0;
        default: return '1;
      endcase
    end
    if (span == 0) return CW'($urandom);
    return CW'(int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic add_ray(int x, int y, int z, int dx, int dy, int dz);
    pending_rays.push_back('{CW'(x), CW'(y), CW'(z), CW'(dx), CW'(dy), CW'(dz)});
  endtask

  // checked between edges so the driver's and monitor's updates have settled
  task automatic wait_idle();
    while (pending_rays.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (12) @(posedge clk);  // pipeline is 7 deep
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx != REG_SPARE) vertex_regs[idx] = val;
    cfg_writes++;
  endtask

  task automatic set_triangle(logic [59:0] va, logic [59:0] vb, logic [59:0] vc);
    write_reg(REG_VERTEX_A, va);
    write_reg(REG_VERTEX_B, vb);
    write_reg(REG_VERTEX_C, vc);
    triangles++;
    @(negedge clk);
  endtask

  task automatic random_triangle(int span);
    set_triangle(vpack(int'(rnd_coord(span)), int'(rnd_coord(span)),
                       int'(rnd_coord(span))),
                 vpack(int'(rnd_coord(span)), int'(rnd_coord(span)),
                       int'(rnd_coord(span))),
                 vpack(int'(rnd_coord(span)), int'(rnd_coord(span)),
                       int'(rnd_coord(span))));
  endtask

  // Mostly lines aimed at a point near the triangle (barycentric weights in
  // 1/256 steps, a little past the far edge sometimes), some jittered, the
  // rest pure noise.
  task automatic run_phase(int n, int span, bit calm);
    ray_t   r;
    longint tgt;
    int     u, v, kind;
    logic signed [CW-1:0] o[3], d[3];
    @(negedge clk);
    steady = calm;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        r = ray_t'(120'({$urandom, $urandom, $urandom, $urandom}));
      end else begin
        u = $urandom_range(256);
        v = $urandom_range(272 - u);
        for (int k = 0; k < 3; k++) begin
          o[k] = rnd_coord(span);
          tgt = vcoord(0, k) + (u * (vcoord(1, k) - vcoord(0, k)) +
                                v * (vcoord(2, k) - vcoord(0, k))) / 256;
          d[k] = CW'(tgt - o[k] + ((kind < 35) ? int'($urandom_range(6)) - 3 : 0));
        end
        r = '{o[0], o[1], o[2], d[0], d[1], d[2]};
      end
      pending_rays.push_back(r);
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // vertices still at reset: all coincide
    @(negedge clk);
    add_ray(1, 2, 3, 4, 5, 6);
    wait_idle();

    // right triangle in the z = 0 plane
    set_triangle(vpack(0, 0, 0), vpack(1000, 0, 0), vpack(0, 1000, 0));
    add_ray(100, 100, -500, 0, 0, 1);
    add_ray(100, 100, 500, 0, 0, 1);      // triangle behind the origin
    add_ray(500, 0, -10, 0, 0, 7);        // on an edge
    add_ray(0, 0, -3, 0, 0, -2);          // through a vertex
    add_ray(500, 500, -1, 0, 0, 1);       // on the long edge
    add_ray(501, 500, -1, 0, 0, 1);
    add_ray(-1, 5, -1, 0, 0, 1);
    add_ray(7, 8, 9, 0, 0, 0);            // zero direction
    add_ray(3, 4, 5, 1, -2, 0);           // parallel to the plane
    add_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    add_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    add_ray(CMIN, CMAX, 0, CMAX, CMIN, -1);
    add_ray(0, 0, 0, CMIN, CMAX, CMIN);
    wait_idle();

    // unmapped index must not disturb the triangle
    write_reg(REG_SPARE, '1);
    @(negedge clk);
    add_ray(100, 100, -500, 0, 0, 1);
    wait_idle();

    // triangle spanning the full coordinate range
    set_triangle(vpack(CMIN, CMIN, CMIN), vpack(CMAX, CMIN, CMIN),
                 vpack(CMIN, CMAX, CMAX));
    add_ray(0, 0, 0, 1, 0, 0);
    add_ray(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX);
    add_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    add_ray(CMAX, CMIN, CMAX, -1, CMAX, CMIN);
    wait_idle();

    // collinear, then two coincident vertices
    set_triangle(vpack(0, 0, 0), vpack(1, 1, 1), vpack(2, 2, 2));
    add_ray(0, 5, 0, 1, 0, 0);
    wait_idle();
    set_triangle(vpack(0, 0, 0), vpack(5, 5, 5), vpack(5, 5, 5));
    add_ray(1, 0, 3, 0, 1, -1);
    wait_idle();

    random_triangle(1 << 17);
    run_phase(100, 1 << 17, 1'b0);
    random_triangle(1 << 17);
    run_phase(100, 1 << 17, 1'b1);
    random_triangle(20);
    run_phase(100, 20, 1'b0);
    random_triangle(0);
    run_phase(100, 0, 1'b0);
    random_triangle(-1);
    run_phase(100, -1, 1'b1);
    random_triangle(1 << 12);
    run_phase(100, 1 << 12, 1'b0);
    random_triangle(1 << 17);
    run_phase(100, 1 << 17, 1'b0);

    $display("%0d lines over %0d triangles (%0d register writes)",
             n_sent, triangles, cfg_writes);
    $display("outcomes: %0d hits, %0d misses, %0d degenerate; %0d mismatches",
             n_hits, n_miss, n_degen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
